[rtl/skf_pkg.sv]
// skf_pkg: shared constants, types and state encoding for the scalar Kalman filter.
// Used by skf_mul, skf_div and scalar_kalman_filter; no dependencies.
package skf_pkg;

  // Field widths (Q16.16 estimate, Q15.16 covariance, Q1.16 gain)
  localparam int EST_W  = 32;
  localparam int COV_W  = 31;
  localparam int GAIN_W = 17;
  localparam int FRAC_W = 16;

  // Shift-add multiplier: parallel multiplicand, serial multiplier bits.
  // cov*A needs 48 signed bits; the difference x - pred needs 33.
  localparam int MC_W      = 48;
  localparam int MP_W      = EST_W + 1;
  localparam int PROD_W    = MC_W + 1 + MP_W;
  localparam int QUO_W     = PROD_W - FRAC_W;
  localparam int MUL_CNT_W = $clog2(MP_W + 1);

  // Restoring divider: gain = pcov * 2^16 / (pcov + R)
  localparam int DIV_W     = COV_W + 1;
  localparam int DIV_CNT_W = $clog2(GAIN_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(65536);
  localparam logic [COV_W-1:0]  COV_MAX   = {COV_W{1'b1}};
  localparam logic [EST_W-1:0]  EST_MAXV  = {1'b0, {(EST_W-1){1'b1}}};
  localparam logic [EST_W-1:0]  EST_MINV  = {1'b1, {(EST_W-1){1'b0}}};

  // Reset values of registers and filter state
  localparam logic [EST_W-1:0] A_RESET   = EST_W'(65536);
  localparam logic [COV_W-1:0] Q_RESET   = COV_W'(655);
  localparam logic [COV_W-1:0] R_RESET   = COV_W'(65536);
  localparam logic [COV_W-1:0] COV_RESET = COV_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANSITION = 2'd0,
    REG_PROC_NOISE = 2'd1,
    REG_MEAS_NOISE = 2'd2
  } cfg_reg_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRED_GO,
    S_PRED_WAIT,
    S_TCOV_GO,
    S_TCOV_WAIT,
    S_PCOV_GO,
    S_PCOV_WAIT,
    S_GAIN_GO,
    S_GAIN_WAIT,
    S_EST_GO,
    S_EST_WAIT,
    S_COV_GO,
    S_COV_WAIT,
    S_DONE
  } skf_state_t;

endpackage

[rtl/skf_mul.sv]
// skf_mul: signed shift-add multiplier, one multiplier bit per cycle.
// Depends on skf_pkg for widths and the unit status struct.
module skf_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [skf_pkg::MC_W-1:0]          mcand,
  input  logic [skf_pkg::MP_W-1:0]          mplier,
  output logic [skf_pkg::PROD_W-1:0]        product,
  output skf_pkg::unit_stat_t               stat
);

  logic [skf_pkg::MC_W-1:0]      mc_r;
  logic [skf_pkg::MC_W:0]        acc_r, acc_nxt;
  logic [skf_pkg::MP_W-1:0]      mp_r, mp_nxt;
  logic [skf_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [skf_pkg::MC_W+1:0]      acc_ext, addend, sum;
  logic                          last;

  // One step: add (or subtract on the sign bit) the multiplicand, shift right
  always_comb begin
    last    = (cnt_r == skf_pkg::MUL_CNT_W'(skf_pkg::MP_W - 1));
    acc_ext = {acc_r[skf_pkg::MC_W], acc_r};
    addend  = mp_r[0] ? {{2{mc_r[skf_pkg::MC_W-1]}}, mc_r} : '0;
    sum     = last ? (acc_ext - addend) : (acc_ext + addend);
    acc_nxt = sum[skf_pkg::MC_W+1:1];
    mp_nxt  = {sum[0], mp_r[skf_pkg::MP_W-1:1]};
    cnt_nxt = cnt_r + skf_pkg::MUL_CNT_W'(1);
  end

  // Control
  always_comb begin
    busy_nxt = start | (busy_r & ~last);
    done_nxt = busy_r & last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mcand;
      acc_r <= '0;
      mp_r  <= mplier;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      mp_r  <= mp_nxt;
    end
  end

  assign product   = {acc_r, mp_r};
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/skf_div.sv]
// skf_div: restoring divider for the gain, one quotient bit per cycle.
// Computes floor(dividend * 2^16 / divisor) for dividend <= divisor; uses skf_pkg.
module skf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [skf_pkg::COV_W-1:0]     dividend,
  input  logic [skf_pkg::DIV_W-1:0]     divisor,
  output logic [skf_pkg::GAIN_W-1:0]    quot,
  output skf_pkg::unit_stat_t           stat
);

  logic [skf_pkg::DIV_W-1:0]     rem_r, rem_nxt, dvs_r;
  logic [skf_pkg::GAIN_W-1:0]    dq_r, dq_nxt;
  logic [skf_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [skf_pkg::DIV_W:0]       trial, diff;
  logic                          qbit, last;

  // Shift in the next dividend bit, trial-subtract the divisor
  always_comb begin
    last    = (cnt_r == skf_pkg::DIV_CNT_W'(skf_pkg::GAIN_W - 1));
    trial   = {rem_r, dq_r[skf_pkg::GAIN_W-1]};
    diff    = trial - {1'b0, dvs_r};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? diff[skf_pkg::DIV_W-1:0] : trial[skf_pkg::DIV_W-1:0];
    dq_nxt  = {dq_r[skf_pkg::GAIN_W-2:0], qbit};
    cnt_nxt = cnt_r + skf_pkg::DIV_CNT_W'(1);
  end

  always_comb begin
    busy_nxt = start | (busy_r & ~last);
    done_nxt = busy_r & last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Dividend is pcov << 16: the top part seeds the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {{(skf_pkg::DIV_W - skf_pkg::COV_W + 1){1'b0}},
                dividend[skf_pkg::COV_W-1:1]};
      dq_r  <= {dividend[0], {(skf_pkg::GAIN_W-1){1'b0}}};
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign quot      = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/scalar_kalman_filter.sv]
// One sample at a time: in_ready is high only in idle, after the last result is loaded.
// The time per sample is set by five 33-step shift-add multiplies and one
// 17-step restoring divide, all run one after another; a held out_ready stalls it.
// Reset (synchronous, rst_n low): estimate 0, covariance 1.0, registers to defaults.
// Top level: sequencer, config registers, clipping and output register;
// uses skf_pkg, skf_mul and skf_div.
module scalar_kalman_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [skf_pkg::EST_W-1:0]  in_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [skf_pkg::EST_W-1:0]  out_estimate,
  output logic [skf_pkg::GAIN_W-1:0]        out_kalman_gain,
  output logic                              out_saturated
);

  localparam int EW = skf_pkg::EST_W;
  localparam int CW = skf_pkg::COV_W;
  localparam int GW = skf_pkg::GAIN_W;
  localparam int QW = skf_pkg::QUO_W;

  skf_pkg::skf_state_t state_r, state_nxt;

  // Registers and filter state
  logic [EW-1:0]           a_r, est_r, x_r, pred_r;
  logic [CW-1:0]           qn_r, rn_r, cov_r, pcov_r;
  logic [skf_pkg::MC_W-1:0] t_r;
  logic [GW-1:0]           gain_r;
  logic                    sat_r;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [EW-1:0]           out_est_r;
  logic [GW-1:0]           out_gain_r;
  logic                    out_sat_r;

  // Unit interfaces
  logic                        mul_start, div_start;
  logic [skf_pkg::MC_W-1:0]    mul_mc;
  logic [skf_pkg::MP_W-1:0]    mul_mp;
  logic [skf_pkg::PROD_W-1:0]  prod;
  skf_pkg::unit_stat_t         mul_stat, div_stat;
  logic [GW-1:0]               div_quot;

  // Datapath intermediates
  logic [QW-1:0]   q;
  logic            pred_ovf, pcov_ovf, est_ovf, cov_neg, cov_big;
  logic [EW-1:0]   pred_clip, est_clip;
  logic [CW:0]     pcov_sum;
  logic [CW-1:0]   pcov_clip, cov_clip;
  logic [skf_pkg::DIV_W-1:0] denom;
  logic            denom_zero;
  logic [EW:0]     diff;
  logic [EW+1:0]   est_sum;
  logic [GW-1:0]   one_minus_gain;
  logic            in_xfer, out_free;

  skf_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mc),
    .mplier  (mul_mp),
    .product (prod),
    .stat    (mul_stat)
  );

  skf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pcov_r),
    .divisor  (denom),
    .quot     (div_quot),
    .stat     (div_stat)
  );

  // Product scaled by 2^-16 (floor), then clipping of each step's result
  always_comb begin
    q = prod[skf_pkg::PROD_W-1:skf_pkg::FRAC_W];

    // pred = clip(est*A)
    pred_ovf  = ~((&q[QW-1:EW-1]) | ~(|q[QW-1:EW-1]));
    pred_clip = pred_ovf ? (q[QW-1] ? skf_pkg::EST_MINV : skf_pkg::EST_MAXV)
                         : q[EW-1:0];

    // pcov = clip(t*A + Q), never negative
    pcov_sum  = {1'b0, q[CW-1:0]} + {1'b0, qn_r};
    pcov_ovf  = (|q[QW-1:CW]) | pcov_sum[CW];
    pcov_clip = pcov_ovf ? skf_pkg::COV_MAX : pcov_sum[CW-1:0];

    denom      = {1'b0, pcov_r} + {1'b0, rn_r};
    denom_zero = (denom == '0);

    // est = pred + gain*(x - pred)
    diff     = {x_r[EW-1], x_r} - {pred_r[EW-1], pred_r};
    est_sum  = {{2{pred_r[EW-1]}}, pred_r} + q[EW+1:0];
    est_ovf  = ~((&est_sum[EW+1:EW-1]) | ~(|est_sum[EW+1:EW-1]));
    est_clip = est_ovf ? (est_sum[EW+1] ? skf_pkg::EST_MINV : skf_pkg::EST_MAXV)
                       : est_sum[EW-1:0];

    // cov = (1 - gain)*pcov
    one_minus_gain = skf_pkg::GAIN_ONE - gain_r;
    cov_neg  = q[QW-1];
    cov_big  = ~q[QW-1] & (|q[QW-2:CW]);
    cov_clip = cov_neg ? '0 : (cov_big ? skf_pkg::COV_MAX : q[CW-1:0]);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skf_pkg::S_IDLE:      if (in_valid) state_nxt = skf_pkg::S_PRED_GO;
      skf_pkg::S_PRED_GO:   state_nxt = skf_pkg::S_PRED_WAIT;
      skf_pkg::S_PRED_WAIT: if (mul_stat.done) state_nxt = skf_pkg::S_TCOV_GO;
      skf_pkg::S_TCOV_GO:   state_nxt = skf_pkg::S_TCOV_WAIT;
      skf_pkg::S_TCOV_WAIT: if (mul_stat.done) state_nxt = skf_pkg::S_PCOV_GO;
      skf_pkg::S_PCOV_GO:   state_nxt = skf_pkg::S_PCOV_WAIT;
      skf_pkg::S_PCOV_WAIT: if (mul_stat.done) state_nxt = skf_pkg::S_GAIN_GO;
      skf_pkg::S_GAIN_GO:   state_nxt = skf_pkg::S_GAIN_WAIT;
      skf_pkg::S_GAIN_WAIT: if (div_stat.done) state_nxt = skf_pkg::S_EST_GO;
      skf_pkg::S_EST_GO:    state_nxt = skf_pkg::S_EST_WAIT;
      skf_pkg::S_EST_WAIT:  if (mul_stat.done) state_nxt = skf_pkg::S_COV_GO;
      skf_pkg::S_COV_GO:    state_nxt = skf_pkg::S_COV_WAIT;
      skf_pkg::S_COV_WAIT:  if (mul_stat.done) state_nxt = skf_pkg::S_DONE;
      skf_pkg::S_DONE:      if (out_free) state_nxt = skf_pkg::S_IDLE;
      default:              state_nxt = skf_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: input ready, unit launches and multiplier operands
  always_comb begin
    in_ready  = (state_r == skf_pkg::S_IDLE);
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_mc    = '0;
    mul_mp    = '0;
    unique case (state_r)
      skf_pkg::S_PRED_GO: begin
        mul_start = 1'b1;
        mul_mc    = {{(skf_pkg::MC_W-EW){est_r[EW-1]}}, est_r};
        mul_mp    = {{(skf_pkg::MP_W-EW){a_r[EW-1]}}, a_r};
      end
      skf_pkg::S_TCOV_GO: begin
        mul_start = 1'b1;
        mul_mc    = {{(skf_pkg::MC_W-CW){1'b0}}, cov_r};
        mul_mp    = {{(skf_pkg::MP_W-EW){a_r[EW-1]}}, a_r};
      end
      skf_pkg::S_PCOV_GO: begin
        mul_start = 1'b1;
        mul_mc    = t_r;
        mul_mp    = {{(skf_pkg::MP_W-EW){a_r[EW-1]}}, a_r};
      end
      skf_pkg::S_GAIN_GO: begin
        div_start = 1'b1;
      end
      skf_pkg::S_EST_GO: begin
        mul_start = 1'b1;
        mul_mc    = {{(skf_pkg::MC_W-EW-1){diff[EW]}}, diff};
        mul_mp    = {{(skf_pkg::MP_W-GW){1'b0}}, gain_r};
      end
      skf_pkg::S_COV_GO: begin
        mul_start = 1'b1;
        mul_mc    = {{(skf_pkg::MC_W-CW){1'b0}}, pcov_r};
        mul_mp    = {{(skf_pkg::MP_W-GW){1'b0}}, one_minus_gain};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign in_xfer  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == skf_pkg::S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      a_r         <= skf_pkg::A_RESET;
      qn_r        <= skf_pkg::Q_RESET;
      rn_r        <= skf_pkg::R_RESET;
      est_r       <= '0;
      cov_r       <= skf_pkg::COV_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          skf_pkg::REG_TRANSITION: a_r  <= cfg_wdata[EW-1:0];
          skf_pkg::REG_PROC_NOISE: qn_r <= cfg_wdata[CW-1:0];
          skf_pkg::REG_MEAS_NOISE: rn_r <= cfg_wdata[CW-1:0];
          default: ;
        endcase
      end
      if (state_r == skf_pkg::S_EST_WAIT && mul_stat.done) begin
        est_r <= est_clip;
      end
      if (state_r == skf_pkg::S_COV_WAIT && mul_stat.done) begin
        cov_r <= cov_clip;
      end
    end
  end

  // Per-sample working registers and output register load
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r   <= in_sample;
      sat_r <= 1'b0;
    end
    if (state_r == skf_pkg::S_PRED_WAIT && mul_stat.done) begin
      pred_r <= pred_clip;
      sat_r  <= sat_r | pred_ovf;
    end
    if (state_r == skf_pkg::S_TCOV_WAIT && mul_stat.done) begin
      t_r <= q[skf_pkg::MC_W-1:0];
    end
    if (state_r == skf_pkg::S_PCOV_WAIT && mul_stat.done) begin
      pcov_r <= pcov_clip;
      sat_r  <= sat_r | pcov_ovf;
    end
    // zero denominator: gain forced to 0
    if (state_r == skf_pkg::S_GAIN_WAIT && div_stat.done) begin
      gain_r <= denom_zero ? '0 : div_quot;
    end
    if (state_r == skf_pkg::S_EST_WAIT && mul_stat.done) begin
      sat_r <= sat_r | est_ovf;
    end
    if (state_r == skf_pkg::S_COV_WAIT && mul_stat.done) begin
      sat_r <= sat_r | cov_neg | cov_big;
    end
    if (state_r == skf_pkg::S_DONE && out_free) begin
      out_est_r  <= est_r;
      out_gain_r <= gain_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_estimate    = out_est_r;
  assign out_kalman_gain = out_gain_r;
  assign out_saturated   = out_sat_r;

  // Checks
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier launched while busy");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_gain_r <= skf_pkg::GAIN_ONE))
    else $error("gain above 1.0");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == skf_pkg::S_DONE))
    else $error("result presented outside the done state");

endmodule
